// File: hw/rtl/csdf_pkg.sv
package csdf_pkg;

  // Field widths of the scan and result items.
  localparam int unsigned CARD_ID_W = 56;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned REC_W     = 32;

  // Default geometry of the cache.
  localparam int unsigned CACHE_ENTRIES_DEF = 8;
  localparam int unsigned ID_BYTES_DEF      = 7;

  // Configuration port.
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned APB_ADDR_W     = 3;
  localparam logic        REG_IDX_DEBOUNCE = 1'b0;
  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd1000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the scan item
    logic scan;      // controller is walking the cache
    logic rd_en;     // read one cache entry
    logic fin_hit;   // finish an item that matched a live entry
    logic fin_miss;  // finish an item that matched nothing
  } csdf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cmp_hit;   // the entry read last cycle is live and matches
  } csdf_status_t;

endpackage

// File: hw/rtl/csdf_ctrl.sv
module csdf_ctrl import csdf_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1,
  localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output csdf_cmd_t        cmd_o,
  output logic [IDX_W-1:0] rd_addr_o,
  input  csdf_status_t     status_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HIT  = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CACHE_ENTRIES);

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Reads are issued one entry per cycle; entry k is compared while entry
  // k+1 is read, so a walk with no match ends in the cycle after the last read.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan  = 1'b1;
        cmd_o.rd_en = (idx_q != LAST_CNT);
        if (status_i.cmp_hit) begin
          state_d = ST_HIT;
        end else if (idx_q == LAST_CNT) begin
          state_d = ST_MISS;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_HIT: begin
        cmd_o.fin_hit = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_MISS: begin
        cmd_o.fin_miss = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign rd_addr_o = idx_q[IDX_W-1:0];

  a_start_enters_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i) |=> (state_q == ST_SCAN && idx_q == '0))
    else $error("accepted scan did not begin a cache walk");

  a_miss_after_full_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MISS) |-> ($past(state_q) == ST_SCAN && $past(idx_q) == LAST_CNT))
    else $error("miss declared before every entry was compared");

endmodule

// File: hw/rtl/csdf_dp.sv
module csdf_dp import csdf_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  parameter int unsigned ID_BYTES      = ID_BYTES_DEF,
  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1,
  localparam int unsigned ID_W  = (ID_BYTES * 8 < CARD_ID_W) ? ID_BYTES * 8 : CARD_ID_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  csdf_cmd_t            cmd_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output csdf_status_t         status_o,
  input  logic [CARD_ID_W-1:0] card_id_i,
  input  logic [TIME_W-1:0]    scan_time_ms_i,
  input  logic [TIME_W-1:0]    debounce_i,
  output logic                 done_o,
  output logic                 accepted_o,
  output logic [REC_W-1:0]     record_number_o,
  output logic                 was_cached_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  // Cache storage. Entries never written since reset are marked by valid_q
  // and read as empty.
  logic [ID_W-1:0]   ids_mem   [CACHE_ENTRIES];
  logic [TIME_W-1:0] times_mem [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] valid_q;

  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] now_q;
  logic [ID_W-1:0]   rd_id_q;
  logic [TIME_W-1:0] rd_time_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_addr_q;
  logic              cmp_vld_q;
  logic [IDX_W-1:0]  hit_addr_q;
  logic              debounce_q;
  logic [IDX_W-1:0]  ptr_q;
  logic [REC_W-1:0]  rec_cnt_q;
  logic [REC_W-1:0]  rec_next;
  logic [TIME_W-1:0] age;
  logic              accept;

  assign age      = now_q - rd_time_q;
  assign rec_next = rec_cnt_q + 1'b1;
  assign accept   = cmd_i.fin_miss | (cmd_i.fin_hit & ~debounce_q);

  assign status_o.cmp_hit = cmp_vld_q & rd_vld_q & (rd_time_q != '0) & (rd_id_q == id_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q  <= card_id_i[ID_W-1:0];
      now_q <= scan_time_ms_i;
    end
    if (cmd_i.rd_en) begin
      rd_id_q   <= ids_mem[rd_addr_i];
      rd_time_q <= times_mem[rd_addr_i];
      rd_vld_q  <= valid_q[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
    if (cmd_i.scan && status_o.cmp_hit) begin
      hit_addr_q <= rd_addr_q;
      debounce_q <= (age < debounce_i);
    end
    if (cmd_i.fin_hit && !debounce_q) begin
      times_mem[hit_addr_q] <= now_q;
    end
    if (cmd_i.fin_miss) begin
      ids_mem[ptr_q]   <= id_q;
      times_mem[ptr_q] <= now_q;
    end
    if (cmd_i.fin_hit || cmd_i.fin_miss) begin
      accepted_o      <= accept;
      record_number_o <= accept ? rec_next : '0;
      was_cached_o    <= cmd_i.fin_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      ptr_q     <= '0;
      rec_cnt_q <= '0;
      cmp_vld_q <= 1'b0;
      done_o    <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.rd_en;
      done_o    <= cmd_i.fin_hit | cmd_i.fin_miss;
      if (accept) begin
        rec_cnt_q <= rec_next;
      end
      if (cmd_i.fin_miss) begin
        valid_q[ptr_q] <= 1'b1;
        ptr_q          <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
      end
    end
  end

  a_record_matches_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && accepted_o) |-> (record_number_o == rec_cnt_q))
    else $error("record number differs from the sequence counter");

  a_debounce_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !accepted_o) |-> (was_cached_o && record_number_o == '0))
    else $error("debounced scan without a cache match");

  a_counter_moves_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin_miss || cmd_i.fin_hit) |=> (done_o && (accepted_o == (rec_cnt_q != $past(rec_cnt_q)))))
    else $error("sequence counter out of step with accepted results");

endmodule

// File: hw/rtl/card_scan_duplicate_filter.sv
// A scan accepted on start_i is captured, then the cache is walked until a live entry
// matches or all are compared; done_o is registered from the hit or miss state.
// A new scan is taken only in the idle state, not while the walk runs through
// the cache memory one entry per cycle on its single read port; busy_o is high meanwhile.
// Reset clears the cache valid bits, replacement pointer and record counter at once;
// the debounce interval returns to 1000 ms. Results cannot be stalled by the receiver.
module card_scan_duplicate_filter import csdf_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  parameter int unsigned ID_BYTES      = ID_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [CARD_ID_W-1:0]  card_id_i,
  input  logic [TIME_W-1:0]     scan_time_ms_i,
  output logic                  done_o,
  output logic                  accepted_o,
  output logic [REC_W-1:0]      record_number_o,
  output logic                  was_cached_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  logic [TIME_W-1:0] debounce_q;
  logic              reg_sel;
  csdf_cmd_t         cmd;
  csdf_status_t      status;
  logic [IDX_W-1:0]  rd_addr;

  // Register index is the word address; only the debounce interval exists.
  assign reg_sel = (paddr[2] == REG_IDX_DEBOUNCE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? debounce_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      debounce_q <= pwdata[TIME_W-1:0];
    end
  end

  csdf_ctrl #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd),
    .rd_addr_o(rd_addr),
    .status_i (status)
  );

  csdf_dp #(
    .CACHE_ENTRIES(CACHE_ENTRIES),
    .ID_BYTES     (ID_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .status_o       (status),
    .card_id_i      (card_id_i),
    .scan_time_ms_i (scan_time_ms_i),
    .debounce_i     (debounce_q),
    .done_o         (done_o),
    .accepted_o     (accepted_o),
    .record_number_o(record_number_o),
    .was_cached_o   (was_cached_o)
  );

endmodule
